FILE: hdl/hrfp_pkg.sv
// Package: widths, byte codes, line layout and hex decode for the hex register frame parser.
`default_nettype none

package hrfp_pkg;

  localparam int ByteW = 8;
  localparam int RegW  = 16;
  localparam int DataW = 32;

  // Line layout
  localparam int LineLen   = 15;
  localparam int PosSat    = 16;
  localparam int PosW      = 5;
  localparam int IdxW      = 4;
  localparam int RegFirst  = 2;
  localparam int RegLast   = 5;
  localparam int DataFirst = 6;
  localparam int DataLast  = 13;

  // Byte codes
  localparam logic [ByteW-1:0] ByteCr   = 8'h0D;
  localparam logic [ByteW-1:0] ByteLf   = 8'h0A;
  localparam logic [ByteW-1:0] ByteStar = 8'h2A;
  localparam logic [ByteW-1:0] ByteD    = 8'h44;

  // Uppercase hex decode: bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_value(input logic [ByteW-1:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = {1'b0, 4'(b[3:0] + 4'd9)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hrfp_if.sv
// Interfaces: valid/ready channels for received bytes and parsed frames.
`default_nettype none

interface hrfp_in_if;
  import hrfp_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hrfp_out_if;
  import hrfp_pkg::*;
  logic             valid;
  logic             ready;
  logic [RegW-1:0]  frame_register;
  logic [DataW-1:0] frame_data;
  logic             ready_now;

  modport source (output valid, output frame_register, output frame_data, output ready_now,
                  input ready);
  modport sink   (input valid, input frame_register, input frame_data, input ready_now,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/hex_register_frame_parser.sv
// Top level: hex register frame parser, one received byte per cycle while in_ch.ready is high.
//
//   channel  dir  word                                      role
//   in_ch    in   rx_byte[7:0]                              received serial byte
//   out_ch   out  frame_register[15:0], frame_data[31:0],   one parsed frame per new
//                 ready_now                                  "*D" line of 15 bytes
//
// One byte per cycle while in_ch.ready is high: the line state and the
// hex accumulators update at the accepting edge, a frame lands in the output register
// on the same edge as its carriage return.
// in_ch.ready is low only while a frame sits in the output register unaccepted.
// Reset (rst, synchronous) clears line state, ready flag and the output valid flag;
// the stored previous line is not cleared and is only compared after a full line.
`default_nettype none

module hex_register_frame_parser (
  input  logic             clk,
  input  logic             rst,
  hrfp_in_if.sink          in_ch,
  hrfp_out_if.source       out_ch
);
  import hrfp_pkg::*;

  // line state
  logic [PosW-1:0]  line_position;
  logic [ByteW-1:0] previous_line [LineLen];
  logic             previous_was_full;
  logic             same_as_previous;
  logic             header_matches;
  logic [RegW-1:0]  register_accum;
  logic             register_stopped;
  logic [DataW-1:0] data_accum;
  logic             data_stopped;
  logic             ready_flag;

  // output register
  logic             out_valid;
  logic [RegW-1:0]  out_register;
  logic [DataW-1:0] out_data;
  logic             out_ready_now;

  logic             accept;
  logic [ByteW-1:0] b;
  logic             is_cr;
  logic             is_lf;
  logic             in_line;
  logic [IdxW-1:0]  idx;
  logic [4:0]       hex;
  logic             hex_ok;
  logic             full;
  logic             emit;
  logic             ready_flag_next;
  logic             in_reg_field;
  logic             in_data_field;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign is_cr       = (b == ByteCr);
  assign is_lf       = (b == ByteLf);
  assign in_line     = (line_position < PosW'(LineLen));
  assign idx         = line_position[IdxW-1:0];
  assign hex         = hex_value(b);
  assign hex_ok      = !hex[4];

  assign in_reg_field  = (line_position >= PosW'(RegFirst)) && (line_position <= PosW'(RegLast));
  assign in_data_field = (line_position >= PosW'(DataFirst)) &&
                         (line_position <= PosW'(DataLast));

  // A line counts as a frame only at exactly 15 bytes, with the header, and when it
  // is not a repeat of the previous line when that line was full.
  assign full  = (line_position == PosW'(LineLen));
  assign emit  = full && header_matches && !(previous_was_full && same_as_previous);

  // Register 0 frames set the ready flag from the data word.
  assign ready_flag_next = (register_accum == '0) ? (data_accum != '0) : ready_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position     <= '0;
      previous_was_full <= 1'b0;
      same_as_previous  <= 1'b1;
      header_matches    <= 1'b1;
      register_accum    <= '0;
      register_stopped  <= 1'b0;
      data_accum        <= '0;
      data_stopped      <= 1'b0;
      ready_flag        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      // A new frame replaces the old one in the same cycle it is taken.
      if (accept && is_cr && emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (accept && is_cr) begin
        previous_was_full <= full;
        line_position     <= '0;
        same_as_previous  <= 1'b1;
        header_matches    <= 1'b1;
        register_accum    <= '0;
        register_stopped  <= 1'b0;
        data_accum        <= '0;
        data_stopped      <= 1'b0;
        if (emit) begin
          ready_flag <= ready_flag_next;
        end
      end else if (accept && !is_lf) begin
        if (in_line) begin
          if (previous_line[idx] != b) begin
            same_as_previous <= 1'b0;
          end
          if (line_position == PosW'(0) && b != ByteStar) begin
            header_matches <= 1'b0;
          end
          if (line_position == PosW'(1) && b != ByteD) begin
            header_matches <= 1'b0;
          end
          if (in_reg_field && !register_stopped) begin
            if (hex_ok) begin
              register_accum <= {register_accum[RegW-5:0], hex[3:0]};
            end else begin
              register_stopped <= 1'b1;
            end
          end
          if (in_data_field && !data_stopped) begin
            if (hex_ok) begin
              data_accum <= {data_accum[DataW-5:0], hex[3:0]};
            end else begin
              data_stopped <= 1'b1;
            end
          end
        end
        if (line_position < PosW'(PosSat)) begin
          line_position <= line_position + PosW'(1);
        end
      end
    end
  end

  // Previous line store: overwritten in place, no reset.
  always_ff @(posedge clk) begin
    if (accept && !is_cr && !is_lf && in_line) begin
      previous_line[idx] <= b;
    end
  end

  // Result payload, loaded with the carriage return of a frame.
  always_ff @(posedge clk) begin
    if (accept && is_cr && emit) begin
      out_register  <= register_accum;
      out_data      <= data_accum;
      out_ready_now <= ready_flag_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.frame_register = out_register;
  assign out_ch.frame_data     = out_data;
  assign out_ch.ready_now      = out_ready_now;

  // Position counter never passes its saturation value.
  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    line_position <= PosW'(PosSat))
    else $error("line position beyond saturation");

  // A carriage return always starts a fresh line.
  a_cr_clears: assert property (@(posedge clk) disable iff (rst)
    accept && is_cr |=> line_position == '0 && header_matches && same_as_previous)
    else $error("line state not cleared after carriage return");

  // Line feeds leave the line untouched.
  a_lf_ignored: assert property (@(posedge clk) disable iff (rst)
    accept && is_lf |=> $stable(line_position) && $stable(data_accum))
    else $error("line feed changed line state");

  // A new frame appears only after an accepted carriage return.
  a_frame_on_cr: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept && is_cr))
    else $error("frame without carriage return");

  // Register 0 frames report the flag derived from their data.
  a_ready_reg0: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_register == '0 |-> out_ready_now == (out_data != '0))
    else $error("ready flag mismatch on register 0 frame");

endmodule

`default_nettype wire

FILE: tb/hex_register_frame_parser_tb.sv
// Testbench for the hex register frame parser: directed lines, backpressure and random lines.
`timescale 1ns / 100ps

module hex_register_frame_parser_tb;
  import hrfp_pkg::*;

  // Run limits. The slowest run (about 850 words, long sender gaps and long
  // receiver stalls, one HoldLen hold) stays well under CycleLimit.
  localparam int CycleLimit  = 500_000;
  localparam int HoldLen     = 300;
  localparam int DrainCycles = 20;
  localparam int ResetCycles = 12;

  // One parsed frame as seen on the output channel.
  typedef struct packed {
    logic [RegW-1:0]  reg_num;
    logic [DataW-1:0] data;
    logic             ready_now;
  } frame_t;

  typedef logic [ByteW-1:0] line_t [$];

  logic clk;
  logic rst;

  hrfp_in_if  in_ch ();
  hrfp_out_if out_ch ();

  hex_register_frame_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Frames the parser owes us, oldest first.
  frame_t expected_frames [$];

  int error_count     = 0;
  int cycle_count     = 0;
  int bytes_sent      = 0;  // accepted words, line feeds not counted
  int frames_expected = 0;

  // Idle / stall percentages for the current phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold: the test bumps holds_asked, the hold process counts it out.
  int holds_asked = 0;
  int holds_taken = 0;
  int hold_count  = 0;

  // Last line sent, kept so the random part can repeat it.
  line_t last_line;

  // ---------------------------------------------------------------------------
  // Line parser state, mirrored from the block's behavior.
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]  line_pos;
  logic [ByteW-1:0] prev_line [LineLen];
  logic             prev_full;
  logic             same_prev;
  logic             header_ok;
  logic [RegW-1:0]  reg_acc;
  logic             reg_stop;
  logic [DataW-1:0] data_acc;
  logic             data_stop;
  logic             ready_flag;

  // Uppercase hex digit value; bit 4 set for anything else.
  function automatic logic [4:0] nibble_of(input logic [ByteW-1:0] b);
    if (b >= "0" && b <= "9") begin
      return {1'b0, 4'(b - "0")};
    end
    if (b >= "A" && b <= "F") begin
      return {1'b0, 4'(b - "A" + 10)};
    end
    return 5'h10;
  endfunction

  function automatic void start_line();
    line_pos  = '0;
    same_prev = 1'b1;
    header_ok = 1'b1;
    reg_acc   = '0;
    reg_stop  = 1'b0;
    data_acc  = '0;
    data_stop = 1'b0;
  endfunction

  // Advance the line state by one accepted word; queue a frame on CR if due.
  task automatic parse_word(input logic [ByteW-1:0] b);
    logic [4:0] v;
    logic       full;
    frame_t     f;
    if (b == ByteLf) begin
      return;
    end
    if (b == ByteCr) begin
      full = (line_pos == LineLen);
      // A full line that matches the previous full line is a repeat: no frame.
      if (full && header_ok && !(prev_full && same_prev)) begin
        if (reg_acc == '0) begin
          ready_flag = (data_acc != '0);
        end
        f.reg_num   = reg_acc;
        f.data      = data_acc;
        f.ready_now = ready_flag;
        expected_frames.push_back(f);
        frames_expected++;
      end
      prev_full = full;
      start_line();
      return;
    end
    if (line_pos < LineLen) begin
      v = nibble_of(b);
      if (prev_line[line_pos[IdxW-1:0]] != b) begin
        same_prev = 1'b0;
      end
      prev_line[line_pos[IdxW-1:0]] = b;
      if (line_pos == 0 && b != ByteStar) begin
        header_ok = 1'b0;
      end
      if (line_pos == 1 && b != ByteD) begin
        header_ok = 1'b0;
      end
      // Each hex field stops for good at its first non-digit.
      if (line_pos >= RegFirst && line_pos <= RegLast && !reg_stop) begin
        if (!v[4]) begin
          reg_acc = {reg_acc[RegW-5:0], v[3:0]};
        end else begin
          reg_stop = 1'b1;
        end
      end
      if (line_pos >= DataFirst && line_pos <= DataLast && !data_stop) begin
        if (!v[4]) begin
          data_acc = {data_acc[DataW-5:0], v[3:0]};
        end else begin
          data_stop = 1'b1;
        end
      end
    end
    if (line_pos < PosSat) begin
      line_pos = line_pos + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver side: long hold counter and ready driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holds_taken != holds_asked) begin
      hold_count  <= HoldLen;
      holds_taken <= holds_asked;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
    end
  end

  always @(posedge clk) begin
    if (hold_count != 0) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Frame checker: every accepted output word against the oldest expectation
  // ---------------------------------------------------------------------------
  frame_t want;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected frame: frame_register %h frame_data %h ready_now %b",
               out_ch.frame_register, out_ch.frame_data, out_ch.ready_now);
        error_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_ch.frame_register !== want.reg_num) begin
          $error("frame_register expected %h actual %h", want.reg_num, out_ch.frame_register);
          error_count++;
        end
        if (out_ch.frame_data !== want.data) begin
          $error("frame_data expected %h actual %h", want.data, out_ch.frame_data);
          error_count++;
        end
        if (out_ch.ready_now !== want.ready_now) begin
          $error("ready_now expected %b actual %b", want.ready_now, out_ch.ready_now);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one word; returns at the edge that accepted it. valid stays high
  // into the next call unless that call decides to idle.
  task automatic send_word(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    parse_word(b);
    if (b != ByteLf) begin
      bytes_sent++;
    end
  endtask

  // Send a line body followed by CR.
  task automatic send_line(input line_t body);
    foreach (body[i]) begin
      send_word(body[i]);
    end
    send_word(ByteCr);
    last_line = body;
  endtask

  function automatic line_t text_bytes(input string s);
    line_t q;
    foreach (s[i]) begin
      q.push_back(s[i]);
    end
    return q;
  endfunction

  function automatic logic [ByteW-1:0] rand_hex_char();
    int n;
    n = $urandom_range(15);
    return (n < 10) ? ByteW'("0" + n) : ByteW'("A" + n - 10);
  endfunction

  // Any byte that does not end or vanish from the line.
  function automatic logic [ByteW-1:0] rand_plain_byte();
    logic [ByteW-1:0] b;
    do begin
      b = ByteW'($urandom_range(255));
    end while (b == ByteCr || b == ByteLf);
    return b;
  endfunction

  // Mostly-valid hex character: now and then a stray byte to end the field early.
  function automatic logic [ByteW-1:0] rand_field_char();
    return ($urandom_range(99) < 92) ? rand_hex_char() : rand_plain_byte();
  endfunction

  // A 15-byte "*D" frame with random content; often register 0 so the
  // ready flag keeps moving.
  function automatic line_t rand_frame();
    line_t q;
    bit    reg_zero;
    reg_zero = ($urandom_range(99) < 25);
    q.push_back(ByteStar);
    q.push_back(ByteD);
    for (int i = RegFirst; i <= RegLast; i++) begin
      q.push_back(reg_zero ? ByteW'("0") : rand_field_char());
    end
    for (int i = DataFirst; i <= DataLast; i++) begin
      // Some zero data words to clear the ready flag.
      q.push_back((reg_zero && $urandom_range(3) == 0) ? ByteW'("0") : rand_field_char());
    end
    q.push_back(rand_plain_byte());
    return q;
  endfunction

  // Sprinkle line feeds; they are dropped and must not shift positions.
  function automatic line_t add_line_feeds(input line_t body);
    line_t q;
    foreach (body[i]) begin
      if ($urandom_range(99) < 4) begin
        q.push_back(ByteLf);
      end
      q.push_back(body[i]);
    end
    return q;
  endfunction

  task automatic send_random_line();
    line_t body;
    int    kind;
    int    n;
    kind = $urandom_range(99);
    if (kind < 58) begin
      body = rand_frame();
    end else if (kind < 72) begin
      // Repeat the last line, sometimes with one field byte changed.
      body = last_line;
      if (body.size() > DataLast && $urandom_range(1) == 1) begin
        body[$urandom_range(DataLast, RegFirst)] = rand_hex_char();
      end
    end else if (kind < 80) begin
      // Right length, broken header.
      body = rand_frame();
      body[$urandom_range(1)] = rand_plain_byte();
    end else if (kind < 90) begin
      // Wrong length (or occasionally right by chance), frame-like content.
      body = rand_frame();
      n = $urandom_range(24);
      while (body.size() > n) begin
        void'(body.pop_back());
      end
      while (body.size() < n) begin
        body.push_back(rand_field_char());
      end
    end else begin
      // Raw noise over the whole byte range; a CR inside ends the line early.
      n = $urandom_range(20, 1);
      repeat (n) begin
        body.push_back(ByteW'($urandom_range(255)));
      end
    end
    send_line(add_line_feeds(body));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-written lines covering the field extremes and every special case.
  task automatic test_directed();
    line_t q;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Register 0 with nonzero data sets the ready flag.
    send_line(text_bytes("*D000000000001Z"));
    // Exact repeat of a full line: nothing.
    send_line(text_bytes("*D000000000001Z"));
    // All-F fields, 0xFF in the ignored last position.
    q = text_bytes("*DFFFFFFFFFFFF");
    q.push_back(8'hFF);
    send_line(q);
    // Register 0 with zero data clears the flag.
    send_line(text_bytes("*D000000000000x"));
    // Lowercase hex ends both fields early.
    send_line(text_bytes("*D00a01234abcd."));
    // Zero bytes are ordinary bytes that stop a hex field.
    q = text_bytes("*D1?239?ABCDEF?");
    q[3]  = 8'h00;
    q[7]  = 8'h00;
    q[14] = 8'h00;
    send_line(q);
    // Over-long line runs the position counter into saturation.
    send_line(text_bytes("*D0001000000020123456"));
    // Short line, then a line equal to an earlier frame counts as new.
    send_line(text_bytes("*D0001"));
    q = text_bytes("*DFFFFFFFFFFFF");
    q.push_back(8'hFF);
    send_line(q);
    // Line feed inside a frame is dropped.
    q = text_bytes("*D00020000ABCD!");
    q.insert(4, ByteLf);
    send_line(q);
    // Bad headers, then a good frame that differs only in the header.
    send_line(text_bytes("*d0003000000011"));
    send_line(text_bytes("+D0003000000011"));
    send_line(text_bytes("*D0003000000011"));
    // Empty line and a lone line feed.
    q.delete();
    send_line(q);
    send_word(ByteLf);
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing
  // frames: the output register fills and the input stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holds_asked   <= holds_asked + 1;
    repeat (6) begin
      send_line(rand_frame());
    end
  endtask

  // Random lines until enough words (and frames, in the last phase) went in.
  task automatic test_random_lines(input int idle_pct, input int stall_pct,
                                   input int words, input int min_frames);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = bytes_sent + words;
    while (bytes_sent < stop_at || frames_expected < min_frames) begin
      send_random_line();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;

    // Predictor starts from the reset state; stored line held as zero.
    foreach (prev_line[i]) begin
      prev_line[i] = '0;
    end
    prev_full  = 1'b0;
    ready_flag = 1'b0;
    start_line();

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_lines(0, 0, 135, 0);
    test_random_lines(73, 0, 135, 0);
    test_random_lines(0, 73, 135, 0);
    test_random_lines(16, 16, 135, 40);

    in_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) begin
      @(posedge clk);
    end
    // A short tail catches any stray frame.
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: hex_register_frame_parser.f
hdl/hrfp_pkg.sv
hdl/hrfp_if.sv
hdl/hex_register_frame_parser.sv
tb/hex_register_frame_parser_tb.sv
